/* hdl/hpx_pkg.sv */
// hpx_pkg: shared widths, matrix constants, CSR register indexes and the
// control word passed between the top level and the scaling divider.
// No dependencies.
`timescale 1ns / 1ps

package hpx_pkg;

   // Field widths
   localparam int PT_W       = 24;   // Q16.8 world coordinate
   localparam int MAG_W      = 24;   // |point - origin|
   localparam int SIZE_W     = 20;   // Q12.8 cell size
   localparam int HEX_W      = 16;   // axial output
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Inverse orientation matrix, Q1.16
   localparam int MAT_BITS = 16;
   localparam int MAT_W    = 17;
   localparam logic [MAT_W-1:0] C_SQRT3_3    = 17'd37837;
   localparam logic [MAT_W-1:0] C_THIRD      = 17'd21845;
   localparam logic [MAT_W-1:0] C_TWO_THIRDS = 17'd43691;

   // Scaled axis magnitude saturates to 2^T_LIM_BITS - 1
   localparam int T_LIM_BITS = 45;

   // Output range
   localparam int HEX_MAX = 32767;
   localparam int HEX_MIN = -32768;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINTY   = 3'd0,
      CSR_ORIGIN_X = 3'd1,
      CSR_ORIGIN_Y = 3'd2,
      CSR_SIZE_X   = 3'd3,
      CSR_SIZE_Y   = 3'd4
   } csr_idx_type;

   // Control word that travels alongside the divider data
   typedef struct packed {
      logic vld;
      logic neg_x;
      logic neg_y;
   } div_ctl_type;

endpackage

/* hdl/hpx_div_pipe.sv */
// hpx_div_pipe: pipelined restoring divider, one quotient bit per stage,
// two lanes (x and y) sharing one control word. Quotient = (mag << (QW - MAG_W)) / size.
// Depends on hpx_pkg.
`timescale 1ns / 1ps

module hpx_div_pipe #(
   parameter int QW = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hpx_pkg::div_ctl_type          in_ctl,
   input  logic [hpx_pkg::MAG_W-1:0]     in_mag_x,
   input  logic [hpx_pkg::MAG_W-1:0]     in_mag_y,
   input  logic [hpx_pkg::SIZE_W-1:0]    size_x,
   input  logic [hpx_pkg::SIZE_W-1:0]    size_y,
   output hpx_pkg::div_ctl_type          out_ctl,
   output logic [QW-1:0]                 out_quo_x,
   output logic [QW-1:0]                 out_quo_y
);

   localparam int MW = hpx_pkg::MAG_W;
   localparam int ZW = QW - MW;
   localparam int SW = hpx_pkg::SIZE_W;

   logic [1:0][SW-1:0]   sz;
   hpx_pkg::div_ctl_type ctl_ff [QW];
   logic [1:0][SW-1:0]   rem_ff [QW];
   logic [1:0][QW-1:0]   acc_ff [QW];

   assign sz = {size_y, size_x};

   for (genvar k = 0; k < QW; k++) begin : g_stage
      hpx_pkg::div_ctl_type c_src;
      logic [1:0][SW-1:0]   r_src;
      logic [1:0][QW-1:0]   a_src;
      logic [1:0][SW:0]     trial;
      logic [1:0]           ge;
      logic [1:0][SW-1:0]   rem_in;
      logic [1:0][QW-1:0]   acc_in;

      // Feed from the ports or the previous stage
      if (k == 0) begin : g_head
         assign c_src = in_ctl;
         assign r_src = '0;
         assign a_src = {{in_mag_y, {ZW{1'b0}}}, {in_mag_x, {ZW{1'b0}}}};
      end else begin : g_body
         assign c_src = ctl_ff[k-1];
         assign r_src = rem_ff[k-1];
         assign a_src = acc_ff[k-1];
      end

      // Shift in the next dividend bit, subtract the size when it fits
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l]  = {r_src[l], a_src[l][QW-1]};
            ge[l]     = trial[l] >= {1'b0, sz[l]};
            rem_in[l] = ge[l] ? SW'(trial[l] - {1'b0, sz[l]}) : trial[l][SW-1:0];
            acc_in[l] = {a_src[l][QW-2:0], ge[l]};
         end
      end

      // Advance every cycle; only the valid bit is reset
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].vld <= 1'b0;
         end else begin
            ctl_ff[k].vld <= c_src.vld;
         end
         ctl_ff[k].neg_x <= c_src.neg_x;
         ctl_ff[k].neg_y <= c_src.neg_y;
         rem_ff[k]       <= rem_in;
         acc_ff[k]       <= acc_in;
      end
   end

   assign out_ctl   = ctl_ff[QW-1];
   assign out_quo_x = acc_ff[QW-1][0];
   assign out_quo_y = acc_ff[QW-1][1];

   // Partial remainder stays below the divisor
   a_rem_x: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QW-1].vld |-> rem_ff[QW-1][0] < size_x)
      else $error("x remainder not below divisor");

   a_rem_y: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QW-1].vld |-> rem_ff[QW-1][1] < size_y)
      else $error("y remainder not below divisor");

   // First stage sees one dividend bit, so its remainder is 0 or 1
   a_rem_head: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[0].vld |-> (rem_ff[0][0] <= SW'(1)) && (rem_ff[0][1] <= SW'(1)))
      else $error("first stage remainder out of range");

endmodule

/* hdl/world_point_to_hex_cell.sv */
// world_point_to_hex_cell: world point to axial hex cell, fully pipelined.
// Depends on hpx_pkg and hpx_div_pipe.
//
//   channel  ports                                      handshake
//   -------  -----------------------------------------  ---------------------------
//   input    req_point_x, req_point_y                   start && !busy
//   result   rsp_hex_q, rsp_hex_r, rsp_clamped          rsp_valid, one-cycle strobe
//   config   csr_idx, csr_wdata                         csr_we
//
// One word enters per cycle while busy is low; each result passes through
// stage A, the bit-per-stage divider that scales each axis by the cell
// size, and then stages T, M, F, S, R1, R2, C and O.
// busy is registered: high during reset, it clears once a clock samples reset low.
// The result side cannot stall, so every stage advances every cycle.
// Reset (synchronous) clears valid bits and loads register defaults.
`timescale 1ns / 1ps

module world_point_to_hex_cell #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [hpx_pkg::PT_W-1:0]        req_point_x,
   input  logic signed [hpx_pkg::PT_W-1:0]        req_point_y,
   output logic                                   rsp_valid,
   output logic signed [hpx_pkg::HEX_W-1:0]       rsp_hex_q,
   output logic signed [hpx_pkg::HEX_W-1:0]       rsp_hex_r,
   output logic                                   rsp_clamped,
   input  logic                                   csr_we,
   input  logic [hpx_pkg::CSR_IDX_W-1:0]          csr_idx,
   input  logic [hpx_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int PW0 = hpx_pkg::PT_W;
   localparam int MW  = hpx_pkg::MAG_W;
   localparam int ZW  = hpx_pkg::SIZE_W;
   localparam int HW  = hpx_pkg::HEX_W;
   localparam int QW  = MW + FRAC_BITS;                      // quotient width
   localparam int TMW = (QW > hpx_pkg::T_LIM_BITS) ? hpx_pkg::T_LIM_BITS : QW;
   localparam int TW  = TMW + 1;                             // signed scaled axis
   localparam int PW  = TW + hpx_pkg::MAT_W + 1;             // product
   localparam int FW  = PW + 1;                              // fractional q, r
   localparam int SW  = FW + 1;                              // fractional s
   localparam int G   = FRAC_BITS + hpx_pkg::MAT_BITS;       // fraction bits
   localparam int RMW = SW - G + 1;                          // rounded magnitude
   localparam int RW  = RMW + 1;                             // rounded signed
   localparam int BW  = RW + 2;                              // rebuilt signed
   localparam int EW  = G + 1;                               // rounding error
   localparam logic [EW-1:0] ERR_HALF = EW'(1) << (G - 1);

   localparam int LQ = 0;
   localparam int LR = 1;
   localparam int LS = 2;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic                  pointy_ff;
   logic signed [PW0-1:0] origin_x_ff;
   logic signed [PW0-1:0] origin_y_ff;
   logic [ZW-1:0]         size_x_ff;
   logic [ZW-1:0]         size_y_ff;
   logic                  busy_ff;

   // Decode a write into its register
   always_ff @(posedge clock) begin
      if (reset) begin
         pointy_ff   <= 1'b1;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         size_x_ff   <= ZW'(256);
         size_y_ff   <= ZW'(256);
      end else if (csr_we) begin
         unique case (hpx_pkg::csr_idx_type'(csr_idx))
            hpx_pkg::CSR_POINTY:   pointy_ff   <= csr_wdata[0];
            hpx_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata[PW0-1:0];
            hpx_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata[PW0-1:0];
            hpx_pkg::CSR_SIZE_X:   size_x_ff   <= csr_wdata[ZW-1:0];
            hpx_pkg::CSR_SIZE_Y:   size_y_ff   <= csr_wdata[ZW-1:0];
            default: ;
         endcase
      end
   end

   // Hold busy through reset; it clears once a clock samples reset low
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------------------
   // Stage A: offset from origin, split into sign and magnitude
   // ---------------------------------------------------------------------------
   logic                  a_vld_in;
   logic signed [PW0:0]   dx;
   logic signed [PW0:0]   dy;
   logic [MW-1:0]         a_mag_x_in;
   logic [MW-1:0]         a_mag_y_in;
   logic                  a_vld_ff;
   logic                  a_neg_x_ff;
   logic                  a_neg_y_ff;
   logic [MW-1:0]         a_mag_x_ff;
   logic [MW-1:0]         a_mag_y_ff;

   always_comb begin
      a_vld_in   = start && !busy_ff;
      dx         = (PW0+1)'(req_point_x) - (PW0+1)'(origin_x_ff);
      dy         = (PW0+1)'(req_point_y) - (PW0+1)'(origin_y_ff);
      a_mag_x_in = dx[PW0] ? MW'(-dx) : dx[MW-1:0];
      a_mag_y_in = dy[PW0] ? MW'(-dy) : dy[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
      a_neg_x_ff <= dx[PW0];
      a_neg_y_ff <= dy[PW0];
      a_mag_x_ff <= a_mag_x_in;
      a_mag_y_ff <= a_mag_y_in;
   end

   // ---------------------------------------------------------------------------
   // Divide stages: scale each axis by its cell size (zero size reads as one)
   // ---------------------------------------------------------------------------
   hpx_pkg::div_ctl_type div_in_ctl;
   hpx_pkg::div_ctl_type div_out_ctl;
   logic [ZW-1:0]        eff_size_x;
   logic [ZW-1:0]        eff_size_y;
   logic [QW-1:0]        quo_x;
   logic [QW-1:0]        quo_y;

   always_comb begin
      div_in_ctl.vld   = a_vld_ff;
      div_in_ctl.neg_x = a_neg_x_ff;
      div_in_ctl.neg_y = a_neg_y_ff;
      eff_size_x       = (size_x_ff == '0) ? ZW'(1) : size_x_ff;
      eff_size_y       = (size_y_ff == '0) ? ZW'(1) : size_y_ff;
   end

   hpx_div_pipe #(
      .QW (QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (div_in_ctl),
      .in_mag_x  (a_mag_x_ff),
      .in_mag_y  (a_mag_y_ff),
      .size_x    (eff_size_x),
      .size_y    (eff_size_y),
      .out_ctl   (div_out_ctl),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y)
   );

   // ---------------------------------------------------------------------------
   // Stage T: saturate the quotient and restore its sign
   // ---------------------------------------------------------------------------
   logic [TMW-1:0]        tmag_x;
   logic [TMW-1:0]        tmag_y;
   logic signed [TW-1:0]  t_x_in;
   logic signed [TW-1:0]  t_y_in;
   logic                  t_vld_ff;
   logic signed [TW-1:0]  t_x_ff;
   logic signed [TW-1:0]  t_y_ff;

   always_comb begin
      tmag_x = (|(quo_x >> hpx_pkg::T_LIM_BITS)) ? '1 : quo_x[TMW-1:0];
      tmag_y = (|(quo_y >> hpx_pkg::T_LIM_BITS)) ? '1 : quo_y[TMW-1:0];
      t_x_in = div_out_ctl.neg_x ? -$signed({1'b0, tmag_x}) : $signed({1'b0, tmag_x});
      t_y_in = div_out_ctl.neg_y ? -$signed({1'b0, tmag_y}) : $signed({1'b0, tmag_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else begin
         t_vld_ff <= div_out_ctl.vld;
      end
      t_x_ff <= t_x_in;
      t_y_ff <= t_y_in;
   end

   // ---------------------------------------------------------------------------
   // Stage M: three matrix products, operands steered by layout
   //   pointy: q = m1 - m2, r = m3    flat: q = m3, r = m1 - m2
   // ---------------------------------------------------------------------------
   logic signed [TW-1:0]  op_a;
   logic signed [TW-1:0]  op_b;
   logic signed [PW-1:0]  m1_in;
   logic signed [PW-1:0]  m2_in;
   logic signed [PW-1:0]  m3_in;
   logic                  m_vld_ff;
   logic signed [PW-1:0]  m1_ff;
   logic signed [PW-1:0]  m2_ff;
   logic signed [PW-1:0]  m3_ff;

   always_comb begin
      op_a  = pointy_ff ? t_x_ff : t_y_ff;
      op_b  = pointy_ff ? t_y_ff : t_x_ff;
      m1_in = op_a * $signed({1'b0, hpx_pkg::C_SQRT3_3});
      m2_in = op_b * $signed({1'b0, hpx_pkg::C_THIRD});
      m3_in = op_b * $signed({1'b0, hpx_pkg::C_TWO_THIRDS});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= t_vld_ff;
      end
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
   end

   // ---------------------------------------------------------------------------
   // Stage F: fractional q and r
   // ---------------------------------------------------------------------------
   logic signed [FW-1:0]  m_diff;
   logic signed [FW-1:0]  f_q_in;
   logic signed [FW-1:0]  f_r_in;
   logic                  f_vld_ff;
   logic signed [FW-1:0]  f_q_ff;
   logic signed [FW-1:0]  f_r_ff;

   always_comb begin
      m_diff = FW'(m1_ff) - FW'(m2_ff);
      f_q_in = pointy_ff ? m_diff : FW'(m3_ff);
      f_r_in = pointy_ff ? FW'(m3_ff) : m_diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= m_vld_ff;
      end
      f_q_ff <= f_q_in;
      f_r_ff <= f_r_in;
   end

   // ---------------------------------------------------------------------------
   // Stage S: third cube coordinate s = -q - r
   // ---------------------------------------------------------------------------
   logic signed [SW-1:0]  s_crd_in [3];
   logic                  s_vld_ff;
   logic signed [SW-1:0]  s_crd_ff [3];

   always_comb begin
      s_crd_in[LQ] = SW'(f_q_ff);
      s_crd_in[LR] = SW'(f_r_ff);
      s_crd_in[LS] = -SW'(f_q_ff) - SW'(f_r_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= f_vld_ff;
      end
      s_crd_ff <= s_crd_in;
   end

   // ---------------------------------------------------------------------------
   // Stage R1: sign and magnitude of each coordinate
   // ---------------------------------------------------------------------------
   logic [SW-1:0]         r1_mag_in [3];
   logic                  r1_vld_ff;
   logic [2:0]            r1_neg_ff;
   logic [SW-1:0]         r1_mag_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r1_mag_in[i] = s_crd_ff[i][SW-1] ? SW'(-s_crd_ff[i]) : SW'(s_crd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
      end else begin
         r1_vld_ff <= s_vld_ff;
      end
      for (int i = 0; i < 3; i++) begin
         r1_neg_ff[i] <= s_crd_ff[i][SW-1];
      end
      r1_mag_ff <= r1_mag_in;
   end

   // ---------------------------------------------------------------------------
   // Stage R2: round half away from zero, keep the exact rounding error
   // ---------------------------------------------------------------------------
   logic [RMW-1:0]        rm [3];
   logic signed [RW-1:0]  r2_rnd_in [3];
   logic [EW-1:0]         r2_err_in [3];
   logic                  r2_vld_ff;
   logic signed [RW-1:0]  r2_rnd_ff [3];
   logic [EW-1:0]         r2_err_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rm[i]        = RMW'(r1_mag_ff[i][SW-1:G]) + RMW'(r1_mag_ff[i][G-1]);
         r2_rnd_in[i] = r1_neg_ff[i] ? -$signed({1'b0, rm[i]}) : $signed({1'b0, rm[i]});
         r2_err_in[i] = r1_mag_ff[i][G-1]
                        ? ({1'b1, {G{1'b0}}} - {1'b0, r1_mag_ff[i][G-1:0]})
                        : {1'b0, r1_mag_ff[i][G-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_vld_ff <= 1'b0;
      end else begin
         r2_vld_ff <= r1_vld_ff;
      end
      r2_rnd_ff <= r2_rnd_in;
      r2_err_ff <= r2_err_in;
   end

   // ---------------------------------------------------------------------------
   // Stage C: rebuild the coordinate with the largest error
   // ---------------------------------------------------------------------------
   logic                  q_worst;
   logic                  s_not_worse;
   logic signed [BW-1:0]  rebuilt_q;
   logic signed [BW-1:0]  rebuilt_r;
   logic signed [BW-1:0]  c_q_in;
   logic signed [BW-1:0]  c_r_in;
   logic                  c_vld_ff;
   logic signed [BW-1:0]  c_q_ff;
   logic signed [BW-1:0]  c_r_ff;

   always_comb begin
      q_worst     = (r2_err_ff[LQ] > r2_err_ff[LS]) && (r2_err_ff[LQ] > r2_err_ff[LR]);
      s_not_worse = r2_err_ff[LS] <= r2_err_ff[LR];
      rebuilt_q   = -BW'(r2_rnd_ff[LS]) - BW'(r2_rnd_ff[LR]);
      rebuilt_r   = -BW'(r2_rnd_ff[LQ]) - BW'(r2_rnd_ff[LS]);
      c_q_in      = q_worst ? rebuilt_q : BW'(r2_rnd_ff[LQ]);
      c_r_in      = (!q_worst && s_not_worse) ? rebuilt_r : BW'(r2_rnd_ff[LR]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= r2_vld_ff;
      end
      c_q_ff <= c_q_in;
      c_r_ff <= c_r_in;
   end

   // ---------------------------------------------------------------------------
   // Stage O: saturate to the output range and flag it
   // ---------------------------------------------------------------------------
   localparam logic signed [BW-1:0] LIM_HI = BW'(hpx_pkg::HEX_MAX);
   localparam logic signed [BW-1:0] LIM_LO = BW'(hpx_pkg::HEX_MIN);

   logic                  q_hi;
   logic                  q_lo;
   logic                  r_hi;
   logic                  r_lo;
   logic signed [HW-1:0]  hex_q_in;
   logic signed [HW-1:0]  hex_r_in;
   logic                  rsp_valid_ff;
   logic signed [HW-1:0]  hex_q_ff;
   logic signed [HW-1:0]  hex_r_ff;
   logic                  clamped_ff;

   always_comb begin
      q_hi     = c_q_ff > LIM_HI;
      q_lo     = c_q_ff < LIM_LO;
      r_hi     = c_r_ff > LIM_HI;
      r_lo     = c_r_ff < LIM_LO;
      hex_q_in = q_hi ? HW'(hpx_pkg::HEX_MAX) : (q_lo ? HW'(hpx_pkg::HEX_MIN) : c_q_ff[HW-1:0]);
      hex_r_in = r_hi ? HW'(hpx_pkg::HEX_MAX) : (r_lo ? HW'(hpx_pkg::HEX_MIN) : c_r_ff[HW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_vld_ff;
      end
      hex_q_ff   <= hex_q_in;
      hex_r_ff   <= hex_r_in;
      clamped_ff <= q_hi || q_lo || r_hi || r_lo;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hex_q   = hex_q_ff;
   assign rsp_hex_r   = hex_r_ff;
   assign rsp_clamped = clamped_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------

   // When q or r was rebuilt, q, r and the rounded s form a valid cube coordinate
   a_cube_sum: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && $past(q_worst || s_not_worse)) |->
         (BW'(c_q_ff + c_r_ff + BW'($past(r2_rnd_ff[LS]))) == '0))
      else $error("cube coordinates do not sum to zero");

   // Rounding error never exceeds one half
   a_err_half: assert property (@(posedge clock) disable iff (reset)
      r2_vld_ff |-> (r2_err_ff[LQ] <= ERR_HALF) && (r2_err_ff[LR] <= ERR_HALF)
                    && (r2_err_ff[LS] <= ERR_HALF))
      else $error("rounding error above one half");

   // A clamped word carries a saturated value
   a_clamp_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped) |->
         (rsp_hex_q == HW'(hpx_pkg::HEX_MAX)) || (rsp_hex_q == HW'(hpx_pkg::HEX_MIN))
         || (rsp_hex_r == HW'(hpx_pkg::HEX_MAX)) || (rsp_hex_r == HW'(hpx_pkg::HEX_MIN)))
      else $error("clamped flag without a saturated value");

endmodule
